// File: sv/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Result status codes, request action codes, cell operations and the
// default sizes used by the top level.
// ---------------------------------------------------------------------------
package spq_pkg;

   // Default sizing
   localparam int DEPTH_DEFAULT         = 16;
   localparam int PRIORITY_BITS_DEFAULT = 16;
   localparam int PAYLOAD_BITS_DEFAULT  = 32;

   // Request action codes
   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE
   } cell_op_type;

   // Control broadcast from the top level to the cells
   typedef struct packed {
      cell_op_type op;
      logic        commit;
   } cell_ctrl_type;

endpackage

// File: sv/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift-register queue
// Holds one entry, compares it against the incoming key and on each
// operation keeps its entry, takes the new entry or takes a neighbor's.
// ---------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
   parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic                     occupied,
   input  logic [PRIORITY_BITS-1:0] new_priority,
   input  logic [PAYLOAD_BITS-1:0]  new_payload,
   input  logic                     left_place,
   input  logic [PRIORITY_BITS-1:0] left_priority,
   input  logic [PAYLOAD_BITS-1:0]  left_payload,
   input  logic [PRIORITY_BITS-1:0] right_priority,
   input  logic [PAYLOAD_BITS-1:0]  right_payload,
   output logic                     place,
   output logic [PRIORITY_BITS-1:0] cell_priority,
   output logic [PAYLOAD_BITS-1:0]  cell_payload
);

   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;
   logic [PAYLOAD_BITS-1:0]  payload_ff, payload_in;

   // New entry belongs at or before this slot
   assign place = !occupied || (priority_ff >= new_priority);

   // Select next contents
   always_comb begin
      priority_in = priority_ff;
      payload_in  = payload_ff;
      if (ctrl.commit) begin
         case (ctrl.op)
            CELL_INSERT: begin
               if (place) begin
                  if (left_place) begin
                     priority_in = left_priority;
                     payload_in  = left_payload;
                  end else begin
                     priority_in = new_priority;
                     payload_in  = new_payload;
                  end
               end
            end
            CELL_REMOVE: begin
               priority_in = right_priority;
               payload_in  = right_payload;
            end
            default: begin
               priority_in = priority_ff;
               payload_in  = payload_ff;
            end
         endcase
      end
   end

   // Hold entry
   always_ff @(posedge clock) begin
      priority_ff <= priority_in;
      payload_ff  <= payload_in;
   end

   assign cell_priority = priority_ff;
   assign cell_payload  = payload_ff;

endmodule

// File: sv/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue: min-first priority queue in a chain of cells
// Entries sit in a row of cells sorted by ascending priority number.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries one item: req_action
//   selects insert (new entry with req_priority_req, req_payload) or remove
//   of the head entry. An insert goes in front of the first entry whose
//   priority is greater or equal, so equal priorities leave newest first.
//   Response channel (rsp_valid/rsp_ready) returns exactly one item per
//   request: status, removed priority and payload (zero unless a remove
//   succeeded) and the entry count after the request.
//   The response is registered. Throughput is one item per cycle while
//   rsp_ready is high: every cell compares against the new key in
//   parallel and shifts by one slot in the same cycle, so no operation
//   walks the chain. A new request is taken while the response register
//   is empty or is being drained in the same cycle; a stalled receiver
//   holds the response and blocks further requests after one.
//   Reset empties the queue (count zero) and drops any pending response.
//   Refused inserts report full, removes on an empty queue report empty.
// ---------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
   parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT,
   localparam int COUNT_BITS   = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   input  logic [PRIORITY_BITS-1:0] req_priority_req,
   input  logic [PAYLOAD_BITS-1:0]  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [PRIORITY_BITS-1:0] rsp_out_priority,
   output logic [PAYLOAD_BITS-1:0]  rsp_out_payload,
   output logic [COUNT_BITS-1:0]    rsp_count
);

   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic [PRIORITY_BITS-1:0] out_priority_ff, out_priority_in;
   logic [PAYLOAD_BITS-1:0]  out_payload_ff, out_payload_in;

   logic                     accept;
   logic                     full;
   logic                     empty;
   cell_ctrl_type            ctrl;
   logic [DEPTH-1:0]         occupied;
   logic [DEPTH-1:0]         place;
   logic [PRIORITY_BITS-1:0] cell_priority [DEPTH];
   logic [PAYLOAD_BITS-1:0]  cell_payload [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == COUNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);

   // Decode request into a cell operation and response
   always_comb begin
      ctrl.op         = CELL_HOLD;
      ctrl.commit     = accept;
      count_in        = count_ff;
      status_in       = status_ff;
      out_priority_in = out_priority_ff;
      out_payload_in  = out_payload_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in    = 1'b1;
         status_in       = STATUS_OK;
         out_priority_in = '0;
         out_payload_in  = '0;
         if (req_action == ACTION_INSERT) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.op  = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ctrl.op         = CELL_REMOVE;
               count_in        = count_ff - 1'b1;
               out_priority_in = cell_priority[0];
               out_payload_in  = cell_payload[0];
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload registers
   always_ff @(posedge clock) begin
      status_ff       <= status_in;
      out_priority_ff <= out_priority_in;
      out_payload_ff  <= out_payload_in;
   end

   // Build the chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     left_place;
      logic [PRIORITY_BITS-1:0] left_priority;
      logic [PAYLOAD_BITS-1:0]  left_payload;
      logic [PRIORITY_BITS-1:0] right_priority;
      logic [PAYLOAD_BITS-1:0]  right_payload;

      assign occupied[i] = (COUNT_BITS'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_place    = 1'b0;
         assign left_priority = req_priority_req;
         assign left_payload  = req_payload;
      end else begin : g_body
         assign left_place    = place[i-1];
         assign left_priority = cell_priority[i-1];
         assign left_payload  = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_priority = '0;
         assign right_payload  = '0;
      end else begin : g_inner
         assign right_priority = cell_priority[i+1];
         assign right_payload  = cell_payload[i+1];
      end

      spq_cell #(
         .PRIORITY_BITS(PRIORITY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .occupied      (occupied[i]),
         .new_priority  (req_priority_req),
         .new_payload   (req_payload),
         .left_place    (left_place),
         .left_priority (left_priority),
         .left_payload  (left_payload),
         .right_priority(right_priority),
         .right_payload (right_payload),
         .place         (place[i]),
         .cell_priority (cell_priority[i]),
         .cell_payload  (cell_payload[i])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = out_priority_ff;
   assign rsp_out_payload  = out_payload_ff;
   assign rsp_count        = count_ff;

endmodule

// File: sv/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the response channel against the queue's status rules.
// ---------------------------------------------------------------------------
module spq_checker
   import spq_pkg::*;
#(
   parameter int DEPTH         = DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEFAULT,
   parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT,
   localparam int COUNT_BITS   = $clog2(DEPTH + 1)
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_status,
   input logic [PRIORITY_BITS-1:0] rsp_out_priority,
   input logic [PAYLOAD_BITS-1:0]  rsp_out_payload,
   input logic [COUNT_BITS-1:0]    rsp_count
);

   // Drop pending response on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_count) && $stable(rsp_out_payload))
      else $error("stalled response changed");

   // Only a successful remove carries an entry
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_out_priority == '0 && rsp_out_payload == '0)
      else $error("failed request returned an entry");

   // Full refusal only at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == COUNT_BITS'(DEPTH))
      else $error("full status below capacity");

   // Empty status only with no entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_count == '0)
      else $error("empty status with entries held");

endmodule

bind sorted_priority_queue spq_checker #(
   .DEPTH        (DEPTH),
   .PRIORITY_BITS(PRIORITY_BITS),
   .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_out_priority(rsp_out_priority),
   .rsp_out_payload (rsp_out_payload),
   .rsp_count       (rsp_count)
);
